/* rtl/stream_range_minimum_query_defines.svh */
// Assertion macros shared by the stream range-minimum checker.
// Depends on nothing; included by files that assert.
`ifndef STREAM_RANGE_MINIMUM_QUERY_DEFINES_SVH
`define STREAM_RANGE_MINIMUM_QUERY_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define SRMQ_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define SRMQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/srmq_pkg.sv */
// Package for the stream range-minimum block: request and response types,
// function and status codes, default sizes. Depends on nothing.
`timescale 1ns / 1ps

package srmq_pkg;

  localparam int SRMQ_DEPTH       = 1024;
  localparam int SRMQ_VALUE_WIDTH = 32;

  localparam logic FUNC_APPEND = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_BAD_IDX = 2'd1;
  localparam logic [1:0] STATUS_FULL    = 2'd2;

  typedef struct packed {
    logic               func;
    logic signed [31:0] value;
    logic        [9:0]  left_index;
  } req_t;

  typedef struct packed {
    logic signed [31:0] minimum;
    logic        [1:0]  status;
  } rsp_t;

endpackage

/* rtl/stream_range_minimum_query.sv */
// Stream range-minimum block: append values, query minimum from a left index.
// Depends on srmq_pkg.
`timescale 1ns / 1ps

// One request at a time. An append is accepted, then compares against the
// stack top and pops entries until it can push; a pop that leaves entries
// behind waits in S_POPWAIT for a stack memory read before the next compare.
// A query walks parent links from the left index up to the root (S_FIND),
// then takes a compressing walk back from the left index (S_COMP).
// The node memory has one read port. A bad index or a full store is
// answered in the accept cycle. Results wait in an output register; a new
// request is taken once that register is free or being taken. The node
// memory holds each index's parent and value; an append writes its own
// entry as a root, so no clearing pass follows reset.
module stream_range_minimum_query import srmq_pkg::*; #(
  parameter int DEPTH       = SRMQ_DEPTH,
  parameter int VALUE_WIDTH = SRMQ_VALUE_WIDTH
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = AW + 1;
  localparam int VW = VALUE_WIDTH;
  localparam int NW = AW + VW;

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_POP     = 5'b00010,
    S_POPWAIT = 5'b00100,
    S_FIND    = 5'b01000,
    S_COMP    = 5'b10000
  } state_t;

  state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] depth, depth_next;
  logic [AW-1:0] top_idx, top_idx_next;
  logic [VW-1:0] top_val, top_val_next;
  logic [AW-1:0] cur_idx, cur_idx_next;
  logic [VW-1:0] cur_val, cur_val_next;
  logic [AW-1:0] root, root_next;
  logic [AW-1:0] left_reg, left_reg_next;

  logic [NW-1:0] node_mem [DEPTH];
  logic [NW-1:0] node_q;
  logic          node_we, node_re;
  logic [AW-1:0] node_waddr, node_raddr;
  logic [NW-1:0] node_wdata;

  logic [NW-1:0] stack_mem [DEPTH];
  logic [NW-1:0] stack_q;
  logic          stack_we, stack_re;
  logic [AW-1:0] stack_waddr, stack_raddr;
  logic [NW-1:0] stack_wdata;

  logic               accept, finish;
  logic [1:0]         fin_status;
  logic signed [31:0] fin_min;
  logic signed [63:0] in_ext, root_ext;
  logic [VW-1:0]      in_val;
  logic [AW-1:0]      q_parent;
  logic [VW-1:0]      q_value;
  logic               do_pop;

  assign req_stall = (state != S_IDLE) || (rsp_valid && rsp_stall);
  assign accept    = req_valid && !req_stall;
  assign in_ext    = 64'(req.value);
  assign in_val    = in_ext[VW-1:0];
  assign root_ext  = 64'($signed(cur_val));
  assign q_parent  = node_q[NW-1:VW];
  assign q_value   = node_q[VW-1:0];
  assign do_pop    = (depth != '0) && ($signed(cur_val) <= $signed(top_val));

  always_comb begin
    state_next   = state;
    count_next   = count;
    depth_next   = depth;
    top_idx_next = top_idx;
    top_val_next = top_val;
    cur_idx_next = cur_idx;
    cur_val_next = cur_val;
    root_next    = root;
    left_reg_next = left_reg;
    node_we = 1'b0; node_waddr = '0; node_wdata = '0;
    node_re = 1'b0; node_raddr = '0;
    stack_we = 1'b0; stack_waddr = '0; stack_wdata = '0;
    stack_re = 1'b0; stack_raddr = '0;
    finish = 1'b0; fin_status = STATUS_OK; fin_min = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (req.func == FUNC_APPEND) begin
            if (count == CW'(DEPTH)) begin
              finish = 1'b1;
              fin_status = STATUS_FULL;
            end else begin
              cur_idx_next = count[AW-1:0];
              cur_val_next = in_val;
              state_next = S_POP;
            end
          end else begin
            if (32'(req.left_index) >= 32'(count)) begin
              finish = 1'b1;
              fin_status = STATUS_BAD_IDX;
            end else begin
              node_re = 1'b1;
              node_raddr = AW'(req.left_index);
              cur_idx_next = AW'(req.left_index);
              left_reg_next = AW'(req.left_index);
              state_next = S_FIND;
            end
          end
        end
      end
      S_POP: begin
        if (do_pop) begin
          // The popped index now points at the new index.
          node_we = 1'b1;
          node_waddr = top_idx;
          node_wdata = {cur_idx, top_val};
          depth_next = depth - CW'(1);
          if (depth > CW'(1)) begin
            stack_re = 1'b1;
            stack_raddr = AW'(depth - CW'(2));
            state_next = S_POPWAIT;
          end
        end else begin
          node_we = 1'b1;
          node_waddr = cur_idx;
          node_wdata = {cur_idx, cur_val};
          stack_we = 1'b1;
          stack_waddr = depth[AW-1:0];
          stack_wdata = {cur_idx, cur_val};
          top_idx_next = cur_idx;
          top_val_next = cur_val;
          depth_next = depth + CW'(1);
          count_next = count + CW'(1);
          finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_POPWAIT: begin
        top_idx_next = stack_q[NW-1:VW];
        top_val_next = stack_q[VW-1:0];
        state_next = S_POP;
      end
      S_FIND: begin
        if (q_parent == cur_idx) begin
          root_next = cur_idx;
          cur_val_next = q_value;
          cur_idx_next = left_reg;
          node_re = 1'b1;
          node_raddr = left_reg;
          state_next = S_COMP;
        end else begin
          cur_idx_next = q_parent;
          node_re = 1'b1;
          node_raddr = q_parent;
        end
      end
      S_COMP: begin
        if (cur_idx == root) begin
          finish = 1'b1;
          fin_min = root_ext[31:0];
          state_next = S_IDLE;
        end else begin
          // Path compression: point this node straight at the root.
          node_we = 1'b1;
          node_waddr = cur_idx;
          node_wdata = {root, q_value};
          node_re = 1'b1;
          node_raddr = q_parent;
          cur_idx_next = q_parent;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (node_we) node_mem[node_waddr] <= node_wdata;
    if (node_re) node_q <= node_mem[node_raddr];
  end

  always_ff @(posedge clk) begin
    if (stack_we) stack_mem[stack_waddr] <= stack_wdata;
    if (stack_re) stack_q <= stack_mem[stack_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      depth <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      depth <= depth_next;
      if (finish) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    top_idx  <= top_idx_next;
    top_val  <= top_val_next;
    cur_idx  <= cur_idx_next;
    cur_val  <= cur_val_next;
    root     <= root_next;
    left_reg <= left_reg_next;
    if (finish) begin
      rsp.minimum <= fin_min;
      rsp.status  <= fin_status;
    end
  end

endmodule

/* rtl/srmq_checker.sv */
// Port-level checker for the stream range-minimum block, with its bind.
// Depends on srmq_pkg and stream_range_minimum_query_defines.svh.
`timescale 1ns / 1ps
`include "stream_range_minimum_query_defines.svh"

module srmq_checker import srmq_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  // A held response stays offered.
  `SRMQ_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid)
  // Only defined status codes appear.
  `SRMQ_ASSERT_NOW(a_status_code, clk, rst, rsp_valid, rsp.status != 2'd3)
  // Flagged responses carry a zero minimum.
  `SRMQ_ASSERT_NOW(a_err_zero, clk, rst, rsp_valid && rsp.status != STATUS_OK,
    rsp.minimum == 32'sd0)
  // An accepted request either keeps the block busy or has already answered.
  `SRMQ_ASSERT_NEXT(a_one_request, clk, rst, req_valid && !req_stall, req_stall || rsp_valid)

endmodule

bind stream_range_minimum_query srmq_checker u_srmq_checker (
  .clk(clk),
  .rst(rst),
  .req_valid(req_valid),
  .req_stall(req_stall),
  .rsp_valid(rsp_valid),
  .rsp_stall(rsp_stall),
  .rsp(rsp)
);
